// ===== rtl/btf_pkg.sv =====
package btf_pkg;

  // Frame layout and CRC constants.
  localparam logic [7:0] FRAME_LEN  = 8'd10;
  localparam logic [7:0] FRAME_TYPE = 8'h08;
  localparam logic [7:0] CRC_POLY   = 8'hD5;
  localparam logic [7:0] ADDR_RESET = 8'hC8;

  // Byte positions within one 12-byte frame.
  localparam int unsigned IDX_W = 4;
  localparam logic [IDX_W-1:0] IDX_ADDR      = 4'd0;
  localparam logic [IDX_W-1:0] IDX_LEN       = 4'd1;
  localparam logic [IDX_W-1:0] IDX_TYPE      = 4'd2;
  localparam logic [IDX_W-1:0] IDX_PAY_FIRST = 4'd3;
  localparam logic [IDX_W-1:0] IDX_PAY_LAST  = 4'd10;
  localparam logic [IDX_W-1:0] IDX_CRC       = 4'd11;

  // Eight payload bytes in transmit order, element 0 sent first.
  localparam int unsigned PAY_BYTES = 8;
  typedef logic [PAY_BYTES-1:0][7:0] payload_t;

  // One byte through the CRC-8, MSB first.
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int b = 0; b < 8; b++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/btf_front.sv =====
module btf_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  // voltage [15:0], current [31:16], capacity [55:32], percent [63:56]
  input  logic [63:0]       in_tdata,
  output logic              q_valid,
  input  logic              q_ready,
  output btf_pkg::payload_t q_data
);

  logic              valid_r;
  logic              valid_nxt;
  btf_pkg::payload_t data_r;
  btf_pkg::payload_t data_nxt;
  logic              accept;

  // The stage takes an item when it is empty or its item moves on.
  assign in_tready = !valid_r || q_ready;
  assign accept    = in_tvalid && in_tready;
  assign q_valid   = valid_r;
  assign q_data    = data_r;

  // Reorder the reading into big-endian transmit order.
  always_comb begin
    data_nxt    = data_r;
    data_nxt[0] = in_tdata[15:8];
    data_nxt[1] = in_tdata[7:0];
    data_nxt[2] = in_tdata[31:24];
    data_nxt[3] = in_tdata[23:16];
    data_nxt[4] = in_tdata[55:48];
    data_nxt[5] = in_tdata[47:40];
    data_nxt[6] = in_tdata[39:32];
    data_nxt[7] = in_tdata[63:56];
  end

  // Stage occupancy.
  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (q_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      data_r <= data_nxt;
    end
  end

endmodule

// ===== rtl/btf_fifo.sv =====
module btf_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  btf_pkg::payload_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output btf_pkg::payload_t out_data
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  btf_pkg::payload_t entry_r [DEPTH];
  logic [PW-1:0]     wr_ptr_r;
  logic [PW-1:0]     wr_ptr_nxt;
  logic [PW-1:0]     rd_ptr_r;
  logic [PW-1:0]     rd_ptr_nxt;
  logic [CW-1:0]     count_r;
  logic [CW-1:0]     count_nxt;
  logic              push;
  logic              pop;

  assign in_ready  = count_r != CW'(DEPTH);
  assign out_valid = count_r != '0;
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_data  = entry_r[rd_ptr_r];

  // Pointer wrap and fill count.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= in_data;
    end
  end

  // The fill count never exceeds the depth.
  assert property (@(posedge clk) disable iff (!rst_n) count_r <= CW'(DEPTH))
    else $error("queue count above depth");

  // A lone push grows the count by one.
  assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> count_r == $past(count_r) + 1'b1)
    else $error("queue count did not grow on push");

endmodule

// ===== rtl/btf_back.sv =====
module btf_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [7:0]        frame_address,
  input  logic              q_valid,
  output logic              q_ready,
  input  btf_pkg::payload_t q_data,
  output logic              out_tvalid,
  input  logic              out_tready,
  // frame_byte [7:0]
  output logic [7:0]        out_tdata,
  output logic              out_tlast
);

  logic [btf_pkg::IDX_W-1:0] idx_r;
  logic [btf_pkg::IDX_W-1:0] idx_nxt;
  logic [btf_pkg::IDX_W-1:0] pay_off;
  logic [7:0]                crc_r;
  logic [7:0]                crc_nxt;
  logic                      out_valid_r;
  logic [7:0]                out_data_r;
  logic                      out_last_r;
  logic [7:0]                byte_sel;
  logic                      load;
  logic                      fire;
  logic                      last_byte;

  // The output register takes a new byte when it is empty or being taken.
  assign load      = !out_valid_r || out_tready;
  assign fire      = load && q_valid;
  assign last_byte = idx_r == btf_pkg::IDX_CRC;
  assign q_ready   = fire && last_byte;
  assign pay_off   = idx_r - btf_pkg::IDX_PAY_FIRST;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // Select the byte at the current frame position.
  always_comb begin
    unique case (idx_r) inside
      btf_pkg::IDX_ADDR: byte_sel = frame_address;
      btf_pkg::IDX_LEN:  byte_sel = btf_pkg::FRAME_LEN;
      btf_pkg::IDX_TYPE: byte_sel = btf_pkg::FRAME_TYPE;
      [btf_pkg::IDX_PAY_FIRST:btf_pkg::IDX_PAY_LAST]:
        byte_sel = q_data[pay_off[2:0]];
      btf_pkg::IDX_CRC:  byte_sel = crc_r;
      default:           byte_sel = 8'h00;
    endcase
  end

  // Frame position and running CRC over type and payload bytes.
  always_comb begin
    idx_nxt = idx_r;
    crc_nxt = crc_r;
    if (fire) begin
      if (last_byte) begin
        idx_nxt = btf_pkg::IDX_ADDR;
        crc_nxt = 8'h00;
      end else begin
        idx_nxt = idx_r + 1'b1;
        if (idx_r >= btf_pkg::IDX_TYPE) begin
          crc_nxt = btf_pkg::crc8_byte(crc_r, byte_sel);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= btf_pkg::IDX_ADDR;
      crc_r       <= 8'h00;
      out_valid_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      crc_r <= crc_nxt;
      if (load) begin
        out_valid_r <= q_valid;
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= byte_sel;
      out_last_r <= last_byte;
    end
  end

  // The frame position stays within one frame.
  assert property (@(posedge clk) disable iff (!rst_n) idx_r <= btf_pkg::IDX_CRC)
    else $error("frame position out of range");

  // A byte taken in with the last marker shows on the output with out_tlast, and the frame position restarts.
  assert property (@(posedge clk) disable iff (!rst_n)
    (fire && last_byte) |=> out_tlast && out_valid_r && idx_r == btf_pkg::IDX_ADDR)
    else $error("frame end not marked or position not restarted");

  // The CRC restarts at zero on every frame's first byte.
  assert property (@(posedge clk) disable iff (!rst_n)
    (idx_r == btf_pkg::IDX_ADDR) |-> crc_r == 8'h00)
    else $error("CRC not cleared at frame start");

endmodule

// ===== rtl/battery_telemetry_framer.sv =====
// Battery telemetry framer.
// The in_ channel takes one battery reading per item; the out_ channel gives
// the resulting 12-byte telemetry frame one byte per item, address first and
// the CRC-8 byte last, with out_tlast high on that CRC byte.
// The cfg_ port writes the frame address byte; write it only while idle.
// The first byte of a frame appears once its reading has gone through the front
// stage and the queue into the output register. The output serializer sends a
// single byte per cycle while out_tready is high, and that sets the reading rate.
// A front stage reorders the reading, a short queue holds pending readings,
// and the back serializer computes the CRC as it sends the bytes, so readings
// keep being accepted while a frame is still going out.
// Reset empties the stages and queue and sets the address to 0xC8.
// When the receiver stalls, the current byte holds on the output, the queue
// fills, and in_tready drops once the front stage and queue are full.
module battery_telemetry_framer #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // battery_voltage [15:0], battery_current [31:16],
  // used_capacity [55:32], charge_remaining [63:56]
  input  logic [63:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // frame_byte [7:0]
  output logic [7:0]  out_tdata,
  output logic        out_tlast,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data
);

  logic [7:0]        frame_address_r;
  logic              front_valid;
  logic              front_ready;
  btf_pkg::payload_t front_data;
  logic              back_valid;
  logic              back_ready;
  btf_pkg::payload_t back_data;

  // Frame address register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_address_r <= btf_pkg::ADDR_RESET;
    end else if (cfg_wr_en) begin
      frame_address_r <= cfg_wr_data;
    end
  end

  btf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_valid   (front_valid),
    .q_ready   (front_ready),
    .q_data    (front_data)
  );

  btf_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .in_data   (front_data),
    .out_valid (back_valid),
    .out_ready (back_ready),
    .out_data  (back_data)
  );

  btf_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .frame_address (frame_address_r),
    .q_valid       (back_valid),
    .q_ready       (back_ready),
    .q_data        (back_data),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tlast     (out_tlast)
  );

endmodule
